FILE: hw/rtl/c2d5_pkg.sv
// c2d5_pkg: widths, register indexes, shared types and the size clamp
// for the 5x5 zero-padded convolution core. No dependencies.
`default_nettype none

package c2d5_pkg;

  localparam int KSIZE     = 5;
  localparam int HALF      = KSIZE / 2;
  localparam int PIX_W     = 8;
  localparam int COEF_W    = 12;
  localparam int DIM_W     = 11;
  localparam int MAX_DIM   = 1024;
  localparam int COL_W     = $clog2(MAX_DIM);
  localparam int POS_W     = 21;
  localparam int LAG_W     = DIM_W + 1;
  localparam int ROW_BITS  = KSIZE * COEF_W;
  localparam int PROD_W    = PIX_W + 1 + COEF_W;
  localparam int RSUM_W    = PROD_W + $clog2(KSIZE);
  localparam int SUM_W     = 25;
  localparam int LB_ROWS   = KSIZE - 1;
  localparam int LB_W      = LB_ROWS * PIX_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF3  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF4  = 3'd6;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd256;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd256;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] win_t;
  typedef logic [KSIZE-1:0][ROW_BITS-1:0] kernel_t;

  // window contents, the in-frame masks of its kernel rows and columns, and the frame-last flag
  typedef struct packed {
    win_t             pix;
    logic [KSIZE-1:0] row_ok;
    logic [KSIZE-1:0] col_ok;
    logic             last;
  } tap_set_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/c2d5_stream_if.sv
// c2d5 stream channels: pixel input and result output, valid/ready.
// Depends on c2d5_pkg for field widths.
`default_nettype none

interface c2d5_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [c2d5_pkg::PIX_W-1:0] pixel;
  modport source (output valid, req_type, pixel, input ready);
  modport sink   (input valid, req_type, pixel, output ready);
endinterface

interface c2d5_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [c2d5_pkg::SUM_W-1:0] conv_sum;
  logic                              frame_last;
  modport source (output valid, conv_sum, frame_last, input ready);
  modport sink   (input valid, conv_sum, frame_last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/conv2d_5x5_zero_pad_core.sv
// conv2d_5x5_zero_pad_core: streaming 5x5 correlation with zero padding.
// Depends on c2d5_pkg, c2d5_stream_if, c2d5_front, c2d5_mac.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+------------------------------------
//   in_ch    | in  | valid/ready       | req_type (1), pixel (8)
//   out_ch   | out | valid/ready       | conv_sum (25, signed), frame_last (1)
//   cfg_*    | in  | cfg_we, no stall  | cfg_index (3), cfg_wdata (60)
//
// One item per cycle unless the output stalls; a result is registered after the item that
// completes its window, which is 2*width+2 items after its own pixel.
// Line buffers are one 1024-deep RAM with one read and one write per cycle.
// Reset is synchronous; the line RAM is not cleared, pad masks hide old data.
// Every stage holds on its own under output stall, so bubbles are squeezed out.
`default_nettype none

module conv2d_5x5_zero_pad_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [c2d5_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [c2d5_pkg::ROW_BITS-1:0]       cfg_wdata,
  c2d5_in_if.sink                            in_ch,
  c2d5_out_if.source                         out_ch
);

  logic [c2d5_pkg::DIM_W-1:0] cfg_width_r, cfg_height_r;
  c2d5_pkg::kernel_t          coef_rows_r;

  logic               tap_valid, tap_ready;
  c2d5_pkg::tap_set_t taps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= c2d5_pkg::WIDTH_RST;
      cfg_height_r <= c2d5_pkg::HEIGHT_RST;
      coef_rows_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        c2d5_pkg::REG_WIDTH:  cfg_width_r    <= cfg_wdata[c2d5_pkg::DIM_W-1:0];
        c2d5_pkg::REG_HEIGHT: cfg_height_r   <= cfg_wdata[c2d5_pkg::DIM_W-1:0];
        c2d5_pkg::REG_COEF0:  coef_rows_r[0] <= cfg_wdata;
        c2d5_pkg::REG_COEF1:  coef_rows_r[1] <= cfg_wdata;
        c2d5_pkg::REG_COEF2:  coef_rows_r[2] <= cfg_wdata;
        c2d5_pkg::REG_COEF3:  coef_rows_r[3] <= cfg_wdata;
        c2d5_pkg::REG_COEF4:  coef_rows_r[4] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  c2d5_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_width  (cfg_width_r),
    .cfg_height (cfg_height_r),
    .tap_valid  (tap_valid),
    .tap_ready  (tap_ready),
    .taps       (taps)
  );

  c2d5_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .taps      (taps),
    .coef_rows (coef_rows_r),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/c2d5_ram.sv
// c2d5_ram: generic simple dual-port RAM, one write and one read port,
// registered read data. No dependencies.
`default_nettype none

module c2d5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire             clk,
  input  wire             we,
  input  wire [AW-1:0]    waddr,
  input  wire [WIDTH-1:0] wdata,
  input  wire             re,
  input  wire [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/c2d5_front.sv
// c2d5_front: frame sequencing, line buffers in one RAM and the 5x5 window.
// Depends on c2d5_pkg, c2d5_stream_if and c2d5_ram.
`default_nettype none

module c2d5_front (
  input  wire                            clk,
  input  wire                            rst_n,
  c2d5_in_if.sink                        in_ch,
  input  wire [c2d5_pkg::DIM_W-1:0]      cfg_width,
  input  wire [c2d5_pkg::DIM_W-1:0]      cfg_height,
  output logic                           tap_valid,
  input  wire                            tap_ready,
  output c2d5_pkg::tap_set_t             taps
);

  // frame position state
  logic [c2d5_pkg::POS_W-1:0] ip_r, ip_nxt;
  logic [c2d5_pkg::DIM_W-1:0] fw_r, fh_r;
  logic [c2d5_pkg::LAG_W-1:0] lag_r;
  logic [c2d5_pkg::COL_W-1:0] in_col_r, in_col_nxt;
  logic [c2d5_pkg::COL_W-1:0] out_col_r, out_col_nxt;
  logic [c2d5_pkg::COL_W-1:0] out_row_r, out_row_nxt;

  logic                       ip_zero, idle_flush, accept, load;
  logic [c2d5_pkg::DIM_W-1:0] fw_eff, fh_eff;
  logic [c2d5_pkg::LAG_W-1:0] lag_eff;
  logic [c2d5_pkg::COL_W-1:0] col_eff;
  logic                       emit, last, out_col_end;
  logic [c2d5_pkg::KSIZE-1:0] row_ok, col_ok;

  // stage 1: item waits for its line buffer read
  logic                       s1_valid_r, s1_valid_nxt;
  c2d5_pkg::pix_t             s1_px_r;
  logic [c2d5_pkg::COL_W-1:0] s1_col_r;
  logic                       s1_emit_r, s1_last_r;
  logic [c2d5_pkg::KSIZE-1:0] s1_row_ok_r, s1_col_ok_r;

  // line buffer RAM and write-to-read forward
  logic [c2d5_pkg::LB_W-1:0]  ram_q, rd_word, wr_word, fwd_word_r;
  logic                       fwd_r;

  // stage 2: window holds the item's taps
  logic                       s2_valid_r, s2_valid_nxt;
  logic                       s2_emit_r, s2_last_r;
  logic [c2d5_pkg::KSIZE-1:0] s2_row_ok_r, s2_col_ok_r;
  c2d5_pkg::win_t             win_r, win_nxt;

  logic s2_free, s1_go, s1_free;

  assign s2_free = !s2_valid_r || !s2_emit_r || tap_ready;
  assign s1_go   = s1_valid_r && s2_free;
  assign s1_free = !s1_valid_r || s2_free;

  assign in_ch.ready = s1_free;
  assign accept      = in_ch.valid && s1_free;
  assign ip_zero     = (ip_r == '0);
  // a flush while no frame is open leaves no trace
  assign idle_flush  = ip_zero && in_ch.req_type;
  assign load        = accept && !idle_flush;

  always_comb begin
    fw_eff  = ip_zero ? c2d5_pkg::clamp_dim(cfg_width)  : fw_r;
    fh_eff  = ip_zero ? c2d5_pkg::clamp_dim(cfg_height) : fh_r;
    lag_eff = ip_zero ? (c2d5_pkg::LAG_W'(c2d5_pkg::HALF) * c2d5_pkg::LAG_W'(fw_eff)
                         + c2d5_pkg::LAG_W'(c2d5_pkg::HALF))
                      : lag_r;
    col_eff = ip_zero ? '0 : in_col_r;

    emit        = (ip_r >= c2d5_pkg::POS_W'(lag_eff));
    out_col_end = ({1'b0, out_col_r} == fw_r - c2d5_pkg::DIM_W'(1));
    last        = emit && out_col_end
                  && ({1'b0, out_row_r} == fh_r - c2d5_pkg::DIM_W'(1));

    for (int m = 0; m < c2d5_pkg::KSIZE; m++) begin
      if (m < c2d5_pkg::HALF) begin
        row_ok[m] = ({1'b0, out_row_r} >= c2d5_pkg::DIM_W'(c2d5_pkg::HALF - m));
        col_ok[m] = ({1'b0, out_col_r} >= c2d5_pkg::DIM_W'(c2d5_pkg::HALF - m));
      end else begin
        row_ok[m] = (({1'b0, out_row_r} + c2d5_pkg::DIM_W'(m - c2d5_pkg::HALF)) < fh_r);
        col_ok[m] = (({1'b0, out_col_r} + c2d5_pkg::DIM_W'(m - c2d5_pkg::HALF)) < fw_r);
      end
    end

    ip_nxt     = last ? '0 : ip_r + c2d5_pkg::POS_W'(1);
    in_col_nxt = ({1'b0, col_eff} == fw_eff - c2d5_pkg::DIM_W'(1)) ? '0
                 : col_eff + c2d5_pkg::COL_W'(1);
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (last) begin
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (emit) begin
      if (out_col_end) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + c2d5_pkg::COL_W'(1);
      end else begin
        out_col_nxt = out_col_r + c2d5_pkg::COL_W'(1);
      end
    end

    s1_valid_nxt = load || (s1_valid_r && !s1_go);
    s2_valid_nxt = s1_go || (s2_valid_r && !s2_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_r       <= '0;
      fw_r       <= '0;
      fh_r       <= '0;
      lag_r      <= '0;
      in_col_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      if (load) begin
        ip_r      <= ip_nxt;
        fw_r      <= fw_eff;
        fh_r      <= fh_eff;
        lag_r     <= lag_eff;
        in_col_r  <= in_col_nxt;
        out_col_r <= out_col_nxt;
        out_row_r <= out_row_nxt;
      end
      if (s1_go) begin
        win_r <= win_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      s1_px_r     <= in_ch.req_type ? '0 : in_ch.pixel;
      s1_col_r    <= col_eff;
      s1_emit_r   <= emit;
      s1_last_r   <= last;
      s1_row_ok_r <= row_ok;
      s1_col_ok_r <= col_ok;
      // previous item writes back the same column this cycle (one-pixel rows)
      fwd_r       <= s1_go && (s1_col_r == col_eff);
      fwd_word_r  <= wr_word;
    end
    if (s1_go) begin
      s2_emit_r   <= s1_emit_r;
      s2_last_r   <= s1_last_r;
      s2_row_ok_r <= s1_row_ok_r;
      s2_col_ok_r <= s1_col_ok_r;
    end
  end

  // lane k of a RAM word holds the pixel k+1 rows above
  assign rd_word = fwd_r ? fwd_word_r : ram_q;
  assign wr_word = {rd_word[c2d5_pkg::LB_W-c2d5_pkg::PIX_W-1:0], s1_px_r};

  c2d5_ram #(
    .WIDTH (c2d5_pkg::LB_W),
    .DEPTH (c2d5_pkg::MAX_DIM)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (wr_word),
    .re    (load),
    .raddr (col_eff),
    .rdata (ram_q)
  );

  // shift the window left, new column enters at the right
  always_comb begin
    for (int m = 0; m < c2d5_pkg::KSIZE; m++) begin
      for (int n = 0; n < c2d5_pkg::KSIZE - 1; n++) begin
        win_nxt[m][n] = win_r[m][n+1];
      end
    end
    win_nxt[c2d5_pkg::KSIZE-1][c2d5_pkg::KSIZE-1] = s1_px_r;
    for (int m = 0; m < c2d5_pkg::KSIZE - 1; m++) begin
      win_nxt[m][c2d5_pkg::KSIZE-1] =
        rd_word[(c2d5_pkg::KSIZE-2-m)*c2d5_pkg::PIX_W +: c2d5_pkg::PIX_W];
    end
  end

  assign tap_valid   = s2_valid_r && s2_emit_r;
  assign taps.pix    = win_r;
  assign taps.row_ok = s2_row_ok_r;
  assign taps.col_ok = s2_col_ok_r;
  assign taps.last   = s2_last_r;

  a_idle_flush_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && idle_flush) |=> !s1_valid_r)
    else $error("idle flush entered the pipeline");

  a_load_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> s1_valid_r)
    else $error("accepted item lost before stage 1");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (ip_r != '0) |-> (({1'b0, out_col_r} < fw_r) && ({1'b0, out_row_r} < fh_r)
                      && ({1'b0, in_col_r} < fw_r)))
    else $error("position counter outside the frame");

endmodule

`default_nettype wire

FILE: hw/rtl/c2d5_mac.sv
// c2d5_mac: masked 5x5 multiply, row sums, total and the result register.
// Depends on c2d5_pkg and c2d5_stream_if.
`default_nettype none

module c2d5_mac (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 tap_valid,
  output logic                tap_ready,
  input  c2d5_pkg::tap_set_t  taps,
  input  c2d5_pkg::kernel_t   coef_rows,
  c2d5_out_if.source          out_ch
);

  typedef logic signed [c2d5_pkg::PROD_W-1:0] prod_t;
  typedef logic signed [c2d5_pkg::RSUM_W-1:0] rsum_t;

  prod_t prod_r   [c2d5_pkg::KSIZE][c2d5_pkg::KSIZE];
  prod_t prod_nxt [c2d5_pkg::KSIZE][c2d5_pkg::KSIZE];
  rsum_t rsum_r   [c2d5_pkg::KSIZE];
  rsum_t rsum_nxt [c2d5_pkg::KSIZE];
  logic signed [c2d5_pkg::SUM_W-1:0] sum_r, sum_nxt;

  logic s3_valid_r, s3_valid_nxt, s3_last_r;
  logic s4_valid_r, s4_valid_nxt, s4_last_r;
  logic out_valid_r, out_valid_nxt, out_last_r;
  logic out_free, s4_free, s3_free, s3_load, s3_go, s4_go;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign s4_free   = !s4_valid_r || out_free;
  assign s3_free   = !s3_valid_r || s4_free;
  assign tap_ready = s3_free;
  assign s3_load   = tap_valid && s3_free;
  assign s3_go     = s3_valid_r && s4_free;
  assign s4_go     = s4_valid_r && out_free;

  always_comb begin
    for (int m = 0; m < c2d5_pkg::KSIZE; m++) begin
      for (int n = 0; n < c2d5_pkg::KSIZE; n++) begin
        // taps outside the frame count as zero
        prod_nxt[m][n] = $signed({1'b0, (taps.row_ok[m] && taps.col_ok[n])
                                        ? taps.pix[m][n] : c2d5_pkg::PIX_W'(0)})
                         * $signed(coef_rows[m][n*c2d5_pkg::COEF_W +: c2d5_pkg::COEF_W]);
      end
    end
    for (int m = 0; m < c2d5_pkg::KSIZE; m++) begin
      rsum_nxt[m] = '0;
      for (int n = 0; n < c2d5_pkg::KSIZE; n++) begin
        rsum_nxt[m] = rsum_nxt[m] + c2d5_pkg::RSUM_W'(prod_r[m][n]);
      end
    end
    sum_nxt = '0;
    for (int m = 0; m < c2d5_pkg::KSIZE; m++) begin
      sum_nxt = sum_nxt + c2d5_pkg::SUM_W'(rsum_r[m]);
    end

    s3_valid_nxt  = s3_load || (s3_valid_r && !s4_free);
    s4_valid_nxt  = s3_go || (s4_valid_r && !out_free);
    out_valid_nxt = s4_go || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s3_valid_r  <= s3_valid_nxt;
      s4_valid_r  <= s4_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      prod_r    <= prod_nxt;
      s3_last_r <= taps.last;
    end
    if (s3_go) begin
      rsum_r    <= rsum_nxt;
      s4_last_r <= s3_last_r;
    end
    if (s4_go) begin
      sum_r      <= sum_nxt;
      out_last_r <= s4_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.conv_sum   = sum_r;
  assign out_ch.frame_last = out_last_r;

endmodule

`default_nettype wire

FILE: test/conv2d_sum_check.sv
// Result checker for conv2d_5x5_zero_pad_core: watches the config port and both
// stream channels, predicts each windowed sum and compares it with the block.
// Depends on c2d5_pkg and the c2d5_in_if / c2d5_out_if interfaces.
module conv2d_sum_check (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [c2d5_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [c2d5_pkg::ROW_BITS-1:0]    cfg_wdata,
  c2d5_in_if                               pix_ch,
  c2d5_out_if                              sum_ch,
  output int                               mismatches,
  output int                               sums_awaited
);
  timeunit 1ns;
  timeprecision 1ps;
  import c2d5_pkg::*;

  localparam int HIST_LEN = 4 * MAX_DIM + 8;

  typedef struct packed {
    logic signed [SUM_W-1:0] conv_sum;
    logic                    frame_last;
  } window_sum_t;

  logic [DIM_W-1:0]    width_reg;
  logic [DIM_W-1:0]    height_reg;
  logic [ROW_BITS-1:0] coef_reg [KSIZE];
  logic [PIX_W-1:0]    pixel_hist [HIST_LEN];
  int unsigned         in_pos;
  int unsigned         out_pos;
  int unsigned         frame_w;
  int unsigned         frame_h;
  window_sum_t         expected_sums [$];

  initial begin
    mismatches   = 0;
    sums_awaited = 0;
  end

  function automatic int unsigned fit_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic predict_window_sum(input logic is_flush, input logic [PIX_W-1:0] px);
    int unsigned             total;
    int unsigned             lag;
    int unsigned             p;
    int                      h;
    int                      w;
    int                      y;
    int                      x;
    int                      idx;
    logic signed [COEF_W-1:0] c;
    longint                  acc;
    window_sum_t             r;
    if (in_pos == 0) begin
      // a flush with no open frame is dropped
      if (is_flush) return;
      frame_w = fit_dim(width_reg);
      frame_h = fit_dim(height_reg);
    end
    total = frame_w * frame_h;
    if (in_pos < total) pixel_hist[in_pos % HIST_LEN] = is_flush ? '0 : px;
    in_pos++;
    lag = HALF * frame_w + HALF;
    if (in_pos <= lag) return;
    p   = out_pos;
    h   = int'(p / frame_w);
    w   = int'(p % frame_w);
    acc = 0;
    for (int m = 0; m < KSIZE; m++) begin
      y = h + m - HALF;
      if (y < 0 || y >= int'(frame_h)) continue;
      for (int n = 0; n < KSIZE; n++) begin
        x = w + n - HALF;
        if (x < 0 || x >= int'(frame_w)) continue;
        idx = y * int'(frame_w) + x;
        c   = coef_reg[m][COEF_W*n +: COEF_W];
        acc += longint'(pixel_hist[idx % HIST_LEN]) * longint'(c);
      end
    end
    r.conv_sum   = acc[SUM_W-1:0];
    r.frame_last = (p == total - 1);
    expected_sums.push_back(r);
    out_pos++;
    if (r.frame_last) begin
      in_pos  = 0;
      out_pos = 0;
    end
  endtask

  task automatic compare_sum();
    window_sum_t e;
    if (expected_sums.size() == 0) begin
      $error("result with nothing pending: conv_sum %0d frame_last %0b",
             sum_ch.conv_sum, sum_ch.frame_last);
      mismatches++;
      return;
    end
    e = expected_sums.pop_front();
    if (sum_ch.conv_sum !== e.conv_sum) begin
      $error("conv_sum: expected %0d, actual %0d", e.conv_sum, sum_ch.conv_sum);
      mismatches++;
    end
    if (sum_ch.frame_last !== e.frame_last) begin
      $error("frame_last: expected %0b, actual %0b", e.frame_last, sum_ch.frame_last);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      for (int m = 0; m < KSIZE; m++) coef_reg[m] = '0;
      in_pos  = 0;
      out_pos = 0;
      frame_w = 0;
      frame_h = 0;
      expected_sums.delete();
    end else begin
      if (pix_ch.valid && pix_ch.ready) predict_window_sum(pix_ch.req_type, pix_ch.pixel);
      if (sum_ch.valid && sum_ch.ready) compare_sum();
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_reg  = cfg_wdata[DIM_W-1:0];
          REG_HEIGHT: height_reg = cfg_wdata[DIM_W-1:0];
          REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3, REG_COEF4: begin
            coef_reg[cfg_index - REG_COEF0] = cfg_wdata;
          end
          default: ;
        endcase
      end
    end
    sums_awaited = expected_sums.size();
  end

endmodule

FILE: test/tb.sv
// Top testbench for conv2d_5x5_zero_pad_core: clock, reset, frame stimulus,
// config writes and receiver back-pressure. Checking lives in conv2d_sum_check.
// Depends on c2d5_pkg, the c2d5 stream interfaces and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import c2d5_pkg::*;

  localparam logic                 REQ_PIXEL     = 1'b0;
  localparam logic                 REQ_FLUSH     = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd7;
  localparam int                   SETTLE_CYCLES = 8;
  localparam int                   HOLD_CYCLES   = 2000;
  localparam int                   RANDOM_ITEMS  = 600;

  typedef enum int {KERN_RANDOM, KERN_MAX, KERN_MIN} kern_kind_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROW_BITS-1:0]  cfg_wdata;
  int                   mismatches;
  int                   sums_awaited;
  int                   src_idle_pct;
  int                   snk_idle_pct;
  int                   hold_left;

  c2d5_in_if  pix_ch ();
  c2d5_out_if sum_ch ();

  conv2d_5x5_zero_pad_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (pix_ch),
    .out_ch    (sum_ch)
  );

  conv2d_sum_check sum_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .pix_ch       (pix_ch),
    .sum_ch       (sum_ch),
    .mismatches   (mismatches),
    .sums_awaited (sums_awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("conv2d_5x5_zero_pad_core regression: fail");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    sum_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        sum_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        sum_ch.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
      end
    end
  end

  function automatic int unsigned frame_dim(input logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(raw);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(3, 0))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_small(input int maxv);
    if ($urandom_range(9, 0) == 0) return '0;
    return DIM_W'($urandom_range(maxv, 1));
  endfunction

  function automatic kernel_t make_kernel(input kern_kind_t kind);
    kernel_t           k;
    logic [COEF_W-1:0] c;
    for (int m = 0; m < KSIZE; m++) begin
      for (int n = 0; n < KSIZE; n++) begin
        case (kind)
          KERN_MAX: c = {1'b0, {(COEF_W-1){1'b1}}};
          KERN_MIN: c = {1'b1, {(COEF_W-1){1'b0}}};
          default: begin
            case ($urandom_range(5, 0))
              0:       c = {1'b0, {(COEF_W-1){1'b1}}};
              1:       c = {1'b1, {(COEF_W-1){1'b0}}};
              2:       c = '0;
              3:       c = COEF_W'($urandom_range(7, 0)) - COEF_W'(3);
              default: c = COEF_W'($urandom);
            endcase
          end
        endcase
        k[m][COEF_W*n +: COEF_W] = c;
      end
    end
    return k;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic rt, input logic [PIX_W-1:0] px);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.req_type <= rt;
    pix_ch.pixel    <= px;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
  endtask

  // drop valid, wait for every pending sum, then let the pipeline empty
  task automatic drain_and_settle();
    pix_ch.valid <= 1'b0;
    do @(negedge clk); while (sums_awaited != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_config(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw,
                             input kernel_t k);
    logic [ROW_BITS-1:0] junk;
    drain_and_settle();
    junk      = ROW_BITS'({$urandom, $urandom});
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= {junk[ROW_BITS-1:DIM_W], w_raw};
    @(negedge clk);
    junk      = ROW_BITS'({$urandom, $urandom});
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= {junk[ROW_BITS-1:DIM_W], h_raw};
    @(negedge clk);
    for (int m = 0; m < KSIZE; m++) begin
      cfg_index <= CFG_IDX_W'(REG_COEF0 + m);
      cfg_wdata <= k[m];
      @(negedge clk);
    end
    cfg_index <= REG_UNUSED;
    cfg_wdata <= ROW_BITS'({$urandom, $urandom});
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one whole frame: pixels with a few early flushes, then the drain
  task automatic run_frame(input int unsigned fw, input int unsigned fh);
    int unsigned total;
    int unsigned span;
    total = fw * fh;
    span  = total + HALF * fw + HALF;
    for (int unsigned i = 0; i < span; i++) begin
      if (i == 0)
        send_item(REQ_PIXEL, rand_pixel());
      else if (i < total)
        send_item(($urandom_range(19, 0) == 0) ? REQ_FLUSH : REQ_PIXEL, rand_pixel());
      else
        send_item(($urandom_range(9, 0) == 0) ? REQ_PIXEL : REQ_FLUSH, rand_pixel());
    end
  endtask

  initial begin
    int               phase;
    int               small_items;
    int               frames;
    logic [DIM_W-1:0] w_raw;
    logic [DIM_W-1:0] h_raw;
    int unsigned      fw;
    int unsigned      fh;
    kern_kind_t       kind;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    pix_ch.valid    = 1'b0;
    pix_ch.req_type = REQ_PIXEL;
    pix_ch.pixel    = '0;
    src_idle_pct    = 0;
    snk_idle_pct    = 0;
    hold_left       = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // flushes with no open frame are ignored
    send_item(REQ_FLUSH, '1);
    send_item(REQ_FLUSH, '0);

    // width zero saturates to one column; early flush and drain pixel
    load_config('0, DIM_W'(3), make_kernel(KERN_MAX));
    send_item(REQ_PIXEL, '1);
    send_item(REQ_FLUSH, '1);
    send_item(REQ_PIXEL, '1);
    send_item(REQ_FLUSH, '0);
    send_item(REQ_PIXEL, 8'h5a);
    send_item(REQ_FLUSH, '1);
    send_item(REQ_FLUSH, '0);

    // height zero saturates to one row, most negative kernel
    load_config(DIM_W'(5), '0, make_kernel(KERN_MIN));
    for (int i = 0; i < 5; i++) send_item(REQ_PIXEL, (i % 2 == 0) ? 8'hff : 8'h00);
    for (int i = 0; i < 12; i++) send_item((i == 6) ? REQ_PIXEL : REQ_FLUSH, 8'ha5);
    send_item(REQ_FLUSH, '1);

    phase       = 0;
    small_items = 0;
    while (small_items < RANDOM_ITEMS) begin
      if (small_items < RANDOM_ITEMS / 3) begin
        src_idle_pct = 10;
        snk_idle_pct = 71;
      end else if (small_items < 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 71;
        snk_idle_pct = 10;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      w_raw  = pick_small(14);
      h_raw  = pick_small(9);
      frames = $urandom_range(4, 1);
      kind = (phase == 1) ? KERN_MAX : (phase == 3) ? KERN_MIN : KERN_RANDOM;
      load_config(w_raw, h_raw, make_kernel(kind));
      fw = frame_dim(w_raw);
      fh = frame_dim(h_raw);
      // hold the receiver off so the core backs up into its input
      if (phase == 2) hold_left = HOLD_CYCLES;
      repeat (frames) begin
        if ($urandom_range(3, 0) == 0) begin
          repeat ($urandom_range(2, 1)) send_item(REQ_FLUSH, rand_pixel());
        end
        run_frame(fw, fh);
        small_items += fw * fh + HALF * fw + HALF;
      end
      phase++;
    end

    // height above the maximum saturates, on a single column
    w_raw = '0;
    h_raw = DIM_W'($urandom_range(2047, MAX_DIM + 1));
    load_config(w_raw, h_raw, make_kernel(KERN_RANDOM));
    run_frame(frame_dim(w_raw), frame_dim(h_raw));

    drain_and_settle();
    if (mismatches == 0) begin
      $display("conv2d_5x5_zero_pad_core regression: pass");
    end else begin
      $display("conv2d_5x5_zero_pad_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/c2d5_pkg.sv
hw/rtl/c2d5_stream_if.sv
hw/rtl/c2d5_ram.sv
hw/rtl/c2d5_front.sv
hw/rtl/c2d5_mac.sv
hw/rtl/conv2d_5x5_zero_pad_core.sv
test/conv2d_sum_check.sv
test/tb.sv
